// ===== hw/rtl/sst_pkg.sv =====
`default_nettype none
package sst_pkg;

  // Sample width is fixed by the payload fields.
  localparam int SAMPLE_BITS   = 16;
  localparam int SET_DEPTH_DEF = 32;
  localparam int TRIM_BITS     = 4;
  localparam int STATUS_BITS   = 2;
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 3;

  localparam logic [STATUS_BITS-1:0] STATUS_OK  = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_FEW = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_OVF = 2'd2;

  // Register index, taken from the word address.
  localparam logic REG_TRIM_COUNT = 1'b0;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t sample_value;
    logic    last_sample;
  } sst_in_t;

  typedef struct packed {
    sample_t                kept_value;
    logic                   last_result;
    logic [STATUS_BITS-1:0] status;
  } sst_out_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } sst_cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sst_cell.sv =====
`default_nettype none
module sst_cell (
  input  logic                   clk,
  input  sst_pkg::sst_cell_ctrl_t ctrl,
  input  sst_pkg::sample_t       sample,
  input  logic                   occ,
  input  logic                   left_occ,
  input  logic                   left_gt,
  input  sst_pkg::sample_t       left_val,
  input  sst_pkg::sample_t       right_val,
  output sst_pkg::sample_t       val,
  output logic                   gt
);
  import sst_pkg::*;

  sample_t val_r;
  sample_t val_nxt;
  logic    take;

  assign gt  = occ && (val_r > sample);
  // A cell moves on insertion if its value is larger than the new sample
  // or if it is the first free cell of the row.
  assign take = gt || (!occ && left_occ);
  assign val  = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.shift) begin
      val_nxt = right_val;
    end else if (ctrl.insert && take) begin
      val_nxt = left_gt ? left_val : sample;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_sample_trimmer.sv =====
`default_nettype none
// Sorted sample trimmer. Samples arrive one per transfer and are inserted in
// ascending order into a row of SET_DEPTH compare-and-shift cells; a sample
// equal to stored ones goes after them. Each sample is placed by a single
// insertion step of the cell row, so another can follow at once while a set
// is collected. The sample marked last closes the set: the row then shifts
// toward cell 0 once per cycle while the output is not held off, dropping
// the first trim_count values and sending out the next count - 2*trim_count.
// An overflowed set, or one with no more than twice trim_count samples,
// gives a single error result. No sample is taken while a set drains.
// Samples beyond SET_DEPTH are dropped and flag the set as overflowed.
// trim_count sits at address 0 of the APB port.
module sorted_sample_trimmer #(
  parameter int SET_DEPTH = sst_pkg::SET_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sst_pkg::sst_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output sst_pkg::sst_out_t                  out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sst_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [sst_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [sst_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import sst_pkg::*;

  localparam int CNT_W = $clog2(SET_DEPTH + 1);
  localparam int CMP_W = ((CNT_W > TRIM_BITS + 1) ? CNT_W : TRIM_BITS + 1) + 1;
  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_DRAIN   = 1'b1;

  logic                   state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [STATUS_BITS-1:0] err_r, err_nxt;
  logic [TRIM_BITS-1:0]   trim_r;
  logic                   out_valid_r, out_valid_nxt;
  sst_out_t               out_data_r, out_data_nxt;

  sst_cell_ctrl_t         ctrl;
  sample_t                vals [SET_DEPTH];
  logic [SET_DEPTH-1:0]   gts;
  logic [SET_DEPTH-1:0]   occs;

  logic                   accept;
  logic                   full;
  logic                   slot_free;
  logic [CNT_W-1:0]       count_ins;
  logic [CMP_W-1:0]       trim_w;
  logic [CMP_W-1:0]       hi_w;
  logic                   idx_last;
  logic                   cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[APB_ADDR_W-1] == REG_TRIM_COUNT) ?
                  {{(APB_DATA_W-TRIM_BITS){1'b0}}, trim_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_r <= '0;
    end else if (cfg_wr && (paddr[APB_ADDR_W-1] == REG_TRIM_COUNT)) begin
      trim_r <= pwdata[TRIM_BITS-1:0];
    end
  end

  // Cell row.
  for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
    assign occs[i] = CNT_W'(i) < count_r;
    sst_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .sample    (in_data.sample_value),
      .occ       (occs[i]),
      .left_occ  ((i == 0) ? 1'b1 : occs[(i == 0) ? 0 : i-1]),
      .left_gt   ((i == 0) ? 1'b0 : gts[(i == 0) ? 0 : i-1]),
      .left_val  (vals[(i == 0) ? 0 : i-1]),
      .right_val (vals[(i == SET_DEPTH-1) ? i : i+1]),
      .val       (vals[i]),
      .gt        (gts[i])
    );
  end

  assign in_ready  = (state_r == ST_COLLECT);
  assign accept    = in_valid && in_ready;
  assign full      = (count_r == CNT_W'(SET_DEPTH));
  assign slot_free = !out_valid_r || out_ready;
  assign count_ins = count_r + CNT_W'(accept && !full);
  assign trim_w    = CMP_W'(trim_r);
  assign hi_w      = CMP_W'(count_r) - trim_w;
  assign idx_last  = (CMP_W'(idx_r) == hi_w - CMP_W'(1));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    ovf_nxt       = ovf_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ctrl.insert   = accept && !full;
    ctrl.shift    = 1'b0;

    case (state_r)
      ST_COLLECT: begin
        if (accept) begin
          count_nxt = count_ins;
          ovf_nxt   = ovf_r || full;
          if (in_data.last_sample) begin
            state_nxt = ST_DRAIN;
            idx_nxt   = '0;
            if (ovf_r || full) begin
              err_nxt = STATUS_OVF;
            end else if (CMP_W'(count_ins) <= (trim_w << 1)) begin
              err_nxt = STATUS_FEW;
            end else begin
              err_nxt = STATUS_OK;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (slot_free) begin
          if (err_r != STATUS_OK) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.kept_value  = '0;
            out_data_nxt.last_result = 1'b1;
            out_data_nxt.status      = err_r;
            count_nxt                = '0;
            ovf_nxt                  = 1'b0;
            state_nxt                = ST_COLLECT;
          end else begin
            ctrl.shift = 1'b1;
            idx_nxt    = idx_r + CNT_W'(1);
            // The first trim_count values leave the row without a transfer.
            if (CMP_W'(idx_r) >= trim_w) begin
              out_valid_nxt            = 1'b1;
              out_data_nxt.kept_value  = vals[0];
              out_data_nxt.last_result = idx_last;
              out_data_nxt.status      = STATUS_OK;
            end
            if (idx_last) begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
              state_nxt = ST_COLLECT;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      count_r     <= '0;
      idx_r       <= '0;
      ovf_r       <= 1'b0;
      err_r       <= STATUS_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      ovf_r       <= ovf_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SET_DEPTH))
    else $error("stored count exceeds the row depth");

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STATUS_OK) |-> out_data.last_result)
    else $error("error result not marked final");

  a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_sample |=> !in_ready)
    else $error("sample taken right after the set closed");

  a_no_shift_insert: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.shift && ctrl.insert))
    else $error("cell row told to insert and shift at once");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
module tb_top;
  import sst_pkg::*;

  localparam int SET_DEPTH = SET_DEPTH_DEF;
  // Extra wait after the last expected result has arrived.
  localparam int SETTLE_CYCLES = 2 * SET_DEPTH + 8;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 45;
  localparam int PLAN_LEN = 27;
  localparam int MAX_PRINTED = 100;

  localparam logic [APB_ADDR_W-1:0] ADDR_TRIM  = 3'd0;
  localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = 3'd4;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [APB_ADDR_W-1:0]  addr;
    logic [SAMPLE_BITS-1:0] data;
    logic                   last;
    logic                   typed;
    sst_out_t               want;
  } plan_row_t;

  localparam sst_out_t NO_WANT = '0;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  sst_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sst_out_t              out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Predicted block state.
  sample_t     set_values[$];
  bit          set_overflow = 1'b0;
  int unsigned trim_now = 0;

  sst_out_t    kept_due[$];
  int          err_count = 0;
  int          send_idle_pct = 34;
  int          recv_idle_pct = 51;

  // Directed sets, run at reset trim first. Rows with a typed result check
  // extremes and error codes; the others go through the predictor.
  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_SAMPLE, ADDR_TRIM, 16'h7FFF, 1'b1, 1'b1, {16'h7FFF, 1'b1, STATUS_OK}},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h8000, 1'b1, 1'b1, {16'h8000, 1'b1, STATUS_OK}},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h0005, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'hFFFD, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h0005, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h0000, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h8000, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h7FFF, 1'b1, 1'b0, NO_WANT},
    '{ROW_WRITE,  ADDR_TRIM, 16'h0002, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h0001, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h0002, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h0003, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h0004, 1'b1, 1'b1, {16'h0000, 1'b1, STATUS_FEW}},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h0009, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h0008, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h0007, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h0006, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'hFFFF, 1'b1, 1'b0, NO_WANT},
    '{ROW_WRITE,  ADDR_SPARE, 16'h0001, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h0001, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h0001, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h0001, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h0001, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'h0001, 1'b1, 1'b0, NO_WANT},
    '{ROW_WRITE,  ADDR_TRIM, 16'h000F, 1'b0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, ADDR_TRIM, 16'hFFFB, 1'b1, 1'b1, {16'h0000, 1'b1, STATUS_FEW}},
    '{ROW_WRITE,  ADDR_TRIM, 16'h0000, 1'b0, 1'b0, NO_WANT}
  };

  sorted_sample_trimmer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    if (err_count < MAX_PRINTED) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    err_count++;
  endtask

  // Inserts one sample into the predicted set and, when it closes the set,
  // returns the kept values or the single error result.
  function automatic void sort_and_trim(input sst_in_t s, output sst_out_t res[$]);
    int       pos;
    int       hi;
    sst_out_t r;
    res.delete();
    if (set_values.size() >= SET_DEPTH) begin
      set_overflow = 1'b1;
    end else begin
      pos = 0;
      while (pos < set_values.size() && set_values[pos] <= s.sample_value) pos++;
      set_values.insert(pos, s.sample_value);
    end
    if (!s.last_sample) return;
    if (set_overflow) begin
      r = '{kept_value: '0, last_result: 1'b1, status: STATUS_OVF};
      res.push_back(r);
    end else if (set_values.size() <= 2 * trim_now) begin
      r = '{kept_value: '0, last_result: 1'b1, status: STATUS_FEW};
      res.push_back(r);
    end else begin
      hi = set_values.size() - trim_now;
      for (int i = trim_now; i < hi; i++) begin
        r = '{kept_value: set_values[i], last_result: (i + 1 == hi), status: STATUS_OK};
        res.push_back(r);
      end
    end
    set_values.delete();
    set_overflow = 1'b0;
  endfunction

  task automatic check_result(input sst_out_t got);
    sst_out_t due;
    if (kept_due.size() == 0) begin
      flag_error($sformatf("unexpected result value %0d status %0d",
                           got.kept_value, got.status));
      return;
    end
    due = kept_due.pop_front();
    if (got.kept_value !== due.kept_value) begin
      flag_error($sformatf("kept_value %0d, expected %0d", got.kept_value, due.kept_value));
    end
    if (got.last_result !== due.last_result) begin
      flag_error($sformatf("last_result %b, expected %b", got.last_result, due.last_result));
    end
    if (got.status !== due.status) begin
      flag_error($sformatf("status %0d, expected %0d", got.status, due.status));
    end
  endtask

  // Result side: check each transfer, then decide the next cycle's stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      check_result(out_data);
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Valid stays high from one item to the next unless a gap is taken, so it
  // is never lowered and raised in the same step.
  task automatic push_sample(input sst_in_t s, input bit typed, input sst_out_t want);
    sst_out_t res[$];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sort_and_trim(s, res);
    if (typed) begin
      kept_due.push_back(want);
    end else begin
      foreach (res[i]) kept_due.push_back(res[i]);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (kept_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, then a read back of trim_count.
  task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_TRIM) trim_now = data[TRIM_BITS-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_TRIM;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== trim_now) begin
      flag_error($sformatf("trim_count reads %0d, expected %0d", prdata, trim_now));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int          ph;
    int          sent;
    int          set_len;
    int          roll;
    int          vstyle;
    int unsigned trims[PHASES];
    sst_in_t     s;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) begin
        wait_idle();
        cfg_write(plan[r].addr, 32'(plan[r].data));
      end else begin
        s.sample_value = plan[r].data;
        s.last_sample  = plan[r].last;
        push_sample(s, plan[r].typed, plan[r].want);
      end
    end

    trims = '{15, 0, $urandom_range(14, 1), 1, 15, $urandom_range(14, 1)};
    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      // Upper data bits are random; only the low four land in the register.
      cfg_write(ADDR_TRIM, ($urandom() & ~32'hF) | trims[ph]);
      send_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 51 : 0;
      recv_idle_pct = (ph < 2) ? 51 : (ph < 4) ? 34 : 0;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        roll = $urandom_range(99);
        if ((ph == 0 && sent == 0) || roll < 6) begin
          set_len = $urandom_range(SET_DEPTH + 8, SET_DEPTH + 1);
        end else if (roll < 16) begin
          set_len = (trim_now > 0) ? $urandom_range(2 * trim_now, 1) : $urandom_range(3, 1);
        end else if (roll < 24) begin
          set_len = SET_DEPTH;
        end else begin
          set_len = 2 * trim_now + $urandom_range(SET_DEPTH - 2 * trim_now, 1);
        end
        // A narrow value range makes duplicates frequent.
        vstyle = $urandom_range(9);
        for (int k = 0; k < set_len; k++) begin
          if (vstyle < 2) begin
            s.sample_value = sample_t'(int'($urandom_range(8)) - 4);
          end else if (vstyle == 2) begin
            s.sample_value = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
          end else begin
            s.sample_value = sample_t'($urandom());
          end
          s.last_sample = (k == set_len - 1);
          push_sample(s, 1'b0, NO_WANT);
          sent++;
        end
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
